// ----- design/csaes_pkg.sv -----
`default_nettype none
package csaes_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH   = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_IV_HIGH    = 3'd2,
    REG_IV_LOW     = 3'd3,
    REG_CHAIN_MODE = 3'd4
  } cfg_reg_t;

  localparam logic [7:0] GF_POLY = 8'h1b;
  localparam logic [7:0] RCON_FIRST = 8'h01;

  localparam logic [7:0] SBOX [256] = '{
    8'h1C,8'h2F,8'h03,8'h53,8'hA3,8'h01,8'h49,8'hDA,8'hA6,8'hCD,8'hE0,8'h8A,8'h19,8'hA7,8'h04,8'hD4,
    8'h06,8'h1A,8'hDA,8'h49,8'h08,8'hE2,8'hF6,8'hB2,8'h9E,8'hE1,8'h22,8'h49,8'hCE,8'h7B,8'h7E,8'h5E,
    8'hA0,8'h09,8'h2A,8'h63,8'hAF,8'h49,8'hCE,8'h70,8'h7B,8'h3C,8'h23,8'h80,8'hFA,8'h17,8'h47,8'hF2,
    8'h62,8'h62,8'h6C,8'h59,8'h10,8'hCC,8'h29,8'h9C,8'hB5,8'h46,8'h58,8'hC7,8'h44,8'h13,8'hE7,8'h38,
    8'hD5,8'hAF,8'h27,8'h83,8'hD4,8'hD5,8'hA0,8'h9E,8'hE3,8'h76,8'h3B,8'h85,8'h04,8'hD9,8'hD6,8'h98,
    8'h60,8'h66,8'hD4,8'h78,8'h53,8'hEA,8'hCA,8'h0E,8'h8D,8'h56,8'h53,8'h44,8'hE2,8'hEF,8'hBD,8'hA9,
    8'h9B,8'h10,8'h0A,8'hA1,8'h13,8'h93,8'hF0,8'h43,8'h0B,8'h7C,8'h39,8'h8A,8'h47,8'hDF,8'hD3,8'hC5,
    8'h0E,8'h34,8'h31,8'hA6,8'hAE,8'h5A,8'hB8,8'hE7,8'hE6,8'h31,8'h43,8'hC0,8'hAA,8'h0F,8'hE0,8'h82,
    8'h12,8'h4C,8'hD1,8'hDF,8'h8B,8'hA5,8'hAC,8'h70,8'hC5,8'h3D,8'h1B,8'h8E,8'h93,8'h17,8'h4D,8'h79,
    8'h4E,8'hCE,8'h63,8'hC4,8'h33,8'h0E,8'h14,8'h57,8'hF0,8'hD8,8'h19,8'h5B,8'h9B,8'h61,8'h71,8'hF2,
    8'h2B,8'h33,8'h7E,8'hFD,8'h2C,8'h0B,8'hB6,8'h23,8'h20,8'hB9,8'hD4,8'h91,8'h19,8'h94,8'h04,8'hA4,
    8'h30,8'h13,8'h8A,8'hF1,8'hD0,8'h05,8'hEC,8'h5E,8'hAC,8'h4A,8'hD4,8'hD6,8'hA5,8'h17,8'h7F,8'hF9,
    8'hE5,8'hF6,8'h00,8'h29,8'hD7,8'h93,8'h2D,8'h5E,8'h2C,8'hF1,8'h81,8'hA3,8'hB7,8'h63,8'h39,8'h57,
    8'hC2,8'h33,8'h87,8'h2D,8'hA8,8'h3F,8'h02,8'hCC,8'h08,8'h67,8'h74,8'h60,8'hD8,8'hF0,8'hDA,8'h67,
    8'h40,8'h64,8'h87,8'h55,8'hBB,8'h7F,8'hF2,8'h10,8'hC9,8'h03,8'h14,8'hB5,8'h80,8'h66,8'hCB,8'h91,
    8'hF6,8'h1F,8'h79,8'h58,8'h88,8'hBC,8'h95,8'hC2,8'h06,8'h5F,8'hE9,8'h09,8'h32,8'hED,8'h9B,8'h85
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [3:0] y);
    logic [7:0] acc;
    logic [7:0] v;
    acc = 8'h00;
    v = x;
    for (int i = 0; i < 4; i++) begin
      if (y[i]) acc = acc ^ v;
      v = xtime(v);
    end
    gf_mul = acc;
  endfunction

  // Byte k of a block sits at bits [127-8k -: 8].
  function automatic logic [127:0] sub_bytes(input logic [127:0] s);
    logic [127:0] o;
    for (int k = 0; k < 16; k++) o[127-8*k -: 8] = SBOX[s[127-8*k -: 8]];
    sub_bytes = o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic right);
    logic [127:0] o;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = right ? (4 * ((c + 3 * r) % 4) + r) : (4 * ((c + r) % 4) + r);
        o[127-8*(4*c+r) -: 8] = s[127-8*src -: 8];
      end
    end
    shift_rows = o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] p0, p1, p2, p3, all;
    for (int c = 0; c < 4; c++) begin
      p0 = s[127-32*c -: 8];
      p1 = s[119-32*c -: 8];
      p2 = s[111-32*c -: 8];
      p3 = s[103-32*c -: 8];
      all = p0 ^ p1 ^ p2 ^ p3;
      o[127-32*c -: 8] = p0 ^ xtime(p0 ^ p1) ^ all;
      o[119-32*c -: 8] = p1 ^ xtime(p1 ^ p2) ^ all;
      o[111-32*c -: 8] = p2 ^ xtime(p2 ^ p3) ^ all;
      o[103-32*c -: 8] = p3 ^ xtime(p3 ^ p0) ^ all;
    end
    mix_columns = o;
  endfunction

  function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a, e, g, d;
    for (int c = 0; c < 4; c++) begin
      a = s[127-32*c -: 8];
      e = s[119-32*c -: 8];
      g = s[111-32*c -: 8];
      d = s[103-32*c -: 8];
      o[127-32*c -: 8] = gf_mul(a, 4'he) ^ gf_mul(e, 4'hb) ^ gf_mul(g, 4'hd) ^ gf_mul(d, 4'h9);
      o[119-32*c -: 8] = gf_mul(a, 4'h9) ^ gf_mul(e, 4'he) ^ gf_mul(g, 4'hb) ^ gf_mul(d, 4'hd);
      o[111-32*c -: 8] = gf_mul(a, 4'hd) ^ gf_mul(e, 4'h9) ^ gf_mul(g, 4'he) ^ gf_mul(d, 4'hb);
      o[103-32*c -: 8] = gf_mul(a, 4'hb) ^ gf_mul(e, 4'hd) ^ gf_mul(g, 4'h9) ^ gf_mul(d, 4'he);
    end
    inv_mix_columns = o;
  endfunction

endpackage
`default_nettype wire

// ----- design/csaes_key_exp.sv -----
`default_nettype none
module csaes_key_exp import csaes_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 10,
  localparam int unsigned IdxW = (ROUND_COUNT + 1 > 1) ? $clog2(ROUND_COUNT + 1) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [127:0]     key,
  input  wire logic [IdxW-1:0]  rd_index,
  output logic      [127:0]     rd_key,
  output logic                  busy
);

  logic [127:0]    rk [ROUND_COUNT+1];
  logic [127:0]    cur;
  logic [127:0]    init_words;
  logic [127:0]    step_words;
  logic [7:0]      rc;
  logic [IdxW-1:0] cnt;
  logic            pend;
  logic            run;
  logic [31:0]     t;
  logic [31:0]     n0, n1, n2, n3;

  // Each 32-bit key word enters the schedule with its bytes reversed.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int r = 0; r < 4; r++) begin
        init_words[127-32*i-8*r -: 8] = key[127-32*i-8*(3-r) -: 8];
      end
    end
  end

  always_comb begin
    t = {SBOX[cur[23:16]] ^ rc, SBOX[cur[15:8]], SBOX[cur[7:0]], SBOX[cur[31:24]]};
    n0 = cur[127:96] ^ t;
    n1 = cur[95:64] ^ n0;
    n2 = cur[63:32] ^ n1;
    n3 = cur[31:0] ^ n2;
    step_words = {n0, n1, n2, n3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b1;
      run  <= 1'b0;
      cnt  <= '0;
      rc   <= RCON_FIRST;
    end else if (pend || start) begin
      run  <= ~start;
      cnt  <= IdxW'(1);
      rc   <= RCON_FIRST;
      pend <= start;
    end else if (run) begin
      rc  <= xtime(rc);
      cnt <= cnt + IdxW'(1);
      if (cnt == IdxW'(ROUND_COUNT)) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && !start) begin
      rk[0] <= init_words;
      cur   <= init_words;
    end else if (run && !start) begin
      rk[cnt] <= step_words;
      cur     <= step_words;
    end
  end

  assign rd_key = rk[rd_index];
  assign busy   = pend | run | start;

endmodule
`default_nettype wire

// ----- design/csaes_round.sv -----
`default_nettype none
module csaes_round import csaes_pkg::*; (
  input  wire logic         decrypt,
  input  wire logic         last,
  input  wire logic [127:0] state_in,
  input  wire logic [127:0] round_key,
  output logic      [127:0] state_out
);

  logic [127:0] enc_s;
  logic [127:0] dec_s;

  always_comb begin
    enc_s = shift_rows(sub_bytes(state_in), 1'b0);
    if (!last) enc_s = mix_columns(enc_s);
    enc_s = enc_s ^ round_key;
    dec_s = sub_bytes(shift_rows(state_in, 1'b1)) ^ round_key;
    if (!last) dec_s = inv_mix_columns(dec_s);
    state_out = decrypt ? dec_s : enc_s;
  end

endmodule
`default_nettype wire

// ----- design/custom_sbox_aes128_ecb_cbc.sv -----
`default_nettype none
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tdata: block_high, block_low; tuser: action, restart_chain
// m_axis    out        tdata: result_high, result_low
// cfg       in         cfg_index selects key_high, key_low, iv_high, iv_low, chain_mode
// A block is loaded, passes once per round through the shared round unit, and
// then its result is held until it is taken.
// After reset and after each key write the key schedule computes one round key
// per cycle, and no beat is accepted meanwhile.
// One block is in flight at a time; s_axis_tready stays low until the result
// beat has been taken.
module custom_sbox_aes128_ecb_cbc import csaes_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [127:0]        s_axis_tdata,  // block_high, block_low
  input  wire logic [1:0]          s_axis_tuser,  // action, restart_chain
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [127:0]        m_axis_tdata   // result_high, result_low
);

  localparam int unsigned IdxW = (ROUND_COUNT + 1 > 1) ? $clog2(ROUND_COUNT + 1) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t          state;
  logic [63:0]     key_high, key_low, iv_high, iv_low;
  logic            chain_mode;
  logic [127:0]    chain;
  logic [127:0]    chain_eff;
  logic [127:0]    blk_in;
  logic [127:0]    saved_in;
  logic [127:0]    work;
  logic [127:0]    round_out;
  logic [127:0]    final_out;
  logic [127:0]    result;
  logic [127:0]    rd_key;
  logic [IdxW-1:0] rnd;
  logic [IdxW-1:0] key_index;
  logic            decrypt;
  logic            last;
  logic            key_busy;
  logic            key_start;
  logic            in_fire;

  assign key_start = cfg_wen && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
  assign s_axis_tready = (state == ST_IDLE) && !key_busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign blk_in = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  assign chain_eff = s_axis_tuser[1] ? {iv_high, iv_low} : chain;
  assign last = (rnd == IdxW'(ROUND_COUNT));
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = {result[63:0], result[127:64]};

  always_comb begin
    unique case (state)
      ST_IDLE: key_index = s_axis_tuser[0] ? IdxW'(ROUND_COUNT) : '0;
      ST_RUN:  key_index = decrypt ? IdxW'(ROUND_COUNT) - rnd : rnd;
      ST_OUT:  key_index = '0;
      default: key_index = '0;
    endcase
  end

  csaes_key_exp #(.ROUND_COUNT(ROUND_COUNT)) u_key_exp (
    .clk      (clk),
    .rst      (rst),
    .start    (key_start),
    .key      ({key_high, key_low}),
    .rd_index (key_index),
    .rd_key   (rd_key),
    .busy     (key_busy)
  );

  csaes_round u_round (
    .decrypt   (decrypt),
    .last      (last),
    .state_in  (work),
    .round_key (rd_key),
    .state_out (round_out)
  );

  assign final_out = (decrypt && chain_mode) ? round_out ^ chain : round_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      iv_high    <= '0;
      iv_low     <= '0;
      chain_mode <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_KEY_HIGH:   key_high   <= cfg_data;
        REG_KEY_LOW:    key_low    <= cfg_data;
        REG_IV_HIGH:    iv_high    <= cfg_data;
        REG_IV_LOW:     iv_low     <= cfg_data;
        REG_CHAIN_MODE: chain_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= '0;
      chain <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_RUN;
            rnd   <= IdxW'(1);
            chain <= chain_eff;
          end
        end
        ST_RUN: begin
          rnd <= rnd + IdxW'(1);
          if (last) begin
            state <= ST_OUT;
            if (chain_mode) chain <= decrypt ? saved_in : round_out;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      decrypt  <= s_axis_tuser[0];
      saved_in <= blk_in;
      if (!s_axis_tuser[0] && chain_mode) work <= blk_in ^ chain_eff ^ rd_key;
      else work <= blk_in ^ rd_key;
    end else if (state == ST_RUN) begin
      work <= round_out;
      if (last) result <= final_out;
    end
  end

endmodule
`default_nettype wire

// ----- bench/custom_sbox_aes128_ecb_cbc_tb.sv -----
module custom_sbox_aes128_ecb_cbc_tb;
  import csaes_pkg::*;

  typedef struct packed {
    logic        action;
    logic        restart;
    logic [63:0] hi;
    logic [63:0] lo;
  } block_req_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wen = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [127:0]        s_axis_tdata = '0;  // block_high, block_low
  logic [1:0]          s_axis_tuser = '0;  // action, restart_chain
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [127:0]        m_axis_tdata;       // result_high, result_low

  custom_sbox_aes128_ecb_cbc DUT (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial forever #4 clk = ~clk;

  // Cipher state mirrored from the block.
  logic [63:0]  key_hi = '0, key_lo = '0, iv_hi = '0, iv_lo = '0;
  logic         cbc_on = 1'b0;
  logic [127:0] chain_blk = '0;
  logic [127:0] round_keys [11];

  block_req_t   pending_blocks [$];
  logic [127:0] expected_blocks [$];
  int           errors = 0;
  int           blocks_taken = 0;
  int           blocks_sent = 0;
  int           results_seen = 0;
  int           hold_req = 0;
  int           hold_served = 0;
  int           src_gap = 0;
  int           sink_gap = 0;
  logic         idle_on = 1'b1;

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_times(input logic [7:0] x, input logic [3:0] y);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (y[i]) acc ^= x;
      x = gf_dbl(x);
    end
    return acc;
  endfunction

  function automatic logic [127:0] subst(input logic [127:0] s);
    for (int k = 0; k < 16; k++) s[127-8*k -: 8] = SBOX[s[127-8*k -: 8]];
    return s;
  endfunction

  function automatic logic [127:0] rotate_rows(input logic [127:0] s, input int dir);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+dir*r)%4)+r) -: 8];
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [7:0] p [4];
    logic [7:0] all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) p[r] = s[127-8*(4*c+r) -: 8];
      all = p[0] ^ p[1] ^ p[2] ^ p[3];
      for (int r = 0; r < 4; r++)
        s[127-8*(4*c+r) -: 8] = p[r] ^ gf_dbl(p[r] ^ p[(r+1)%4]) ^ all;
    end
    return s;
  endfunction

  function automatic logic [127:0] unmix_cols(input logic [127:0] s);
    logic [7:0] p [4];
    logic [3:0] coef [4];
    logic [7:0] acc;
    coef = '{4'he, 4'hb, 4'hd, 4'h9};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) p[r] = s[127-8*(4*c+r) -: 8];
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int j = 0; j < 4; j++) acc ^= gf_times(p[j], coef[(j-r+4)%4]);
        s[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return s;
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] s);
    s ^= round_keys[0];
    for (int n = 1; n < 10; n++) s = mix_cols(rotate_rows(subst(s), 1)) ^ round_keys[n];
    return rotate_rows(subst(s), 1) ^ round_keys[10];
  endfunction

  function automatic logic [127:0] decrypt_block(input logic [127:0] s);
    s ^= round_keys[10];
    for (int n = 9; n > 0; n--) s = unmix_cols(subst(rotate_rows(s, 3)) ^ round_keys[n]);
    return subst(rotate_rows(s, 3)) ^ round_keys[0];
  endfunction

  // Key words enter the schedule with their bytes reversed.
  task automatic expand_key();
    logic [7:0]   w [176];
    logic [7:0]   t [4];
    logic [7:0]   tmp;
    logic [7:0]   rc;
    logic [127:0] kb;
    kb = {key_hi, key_lo};
    rc = RCON_FIRST;
    for (int i = 0; i < 16; i++) w[i] = kb[127-8*(4*(i/4)+3-i%4) -: 8];
    for (int i = 4; i < 44; i++) begin
      for (int r = 0; r < 4; r++) t[r] = w[4*(i-1)+r];
      if (i % 4 == 0) begin
        tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
        for (int r = 0; r < 4; r++) t[r] = SBOX[t[r]];
        t[0] ^= rc;
        rc = gf_dbl(rc);
      end
      for (int r = 0; r < 4; r++) w[4*i+r] = w[4*(i-4)+r] ^ t[r];
    end
    for (int n = 0; n < 11; n++)
      for (int k = 0; k < 16; k++) round_keys[n][127-8*k -: 8] = w[16*n+k];
  endtask

  task automatic cipher_step(input block_req_t b, output logic [127:0] res);
    logic [127:0] din;
    din = {b.hi, b.lo};
    if (b.restart) chain_blk = {iv_hi, iv_lo};
    if (!b.action) begin
      res = encrypt_block(cbc_on ? din ^ chain_blk : din);
      if (cbc_on) chain_blk = res;
    end else begin
      res = decrypt_block(din);
      if (cbc_on) begin
        res ^= chain_blk;
        chain_blk = din;
      end
    end
  endtask

  always @(negedge clk) begin
    block_req_t b;
    logic took;
    took = blocks_taken != blocks_sent;
    blocks_sent = blocks_taken;
    if (!s_axis_tvalid || took) begin
      if (src_gap == 0 && idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 12);
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        b = pending_blocks.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b.lo, b.hi};
        s_axis_tuser <= {b.restart, b.action};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_served && m_axis_tvalid) begin
      hold_served = hold_req;
      sink_gap = 400;
    end else if (sink_gap == 0 && idle_on && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 12);
    end
    if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    block_req_t   b;
    logic [127:0] res;
    logic [127:0] want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_blocks.size() == 0) begin
          $error("result beat with no block outstanding: %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          if (m_axis_tdata[63:0] !== want[127:64]) begin
            $error("result_high: expected %h, actual %h", want[127:64], m_axis_tdata[63:0]);
            errors++;
          end
          if (m_axis_tdata[127:64] !== want[63:0]) begin
            $error("result_low: expected %h, actual %h", want[63:0], m_axis_tdata[127:64]);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        b.action = s_axis_tuser[0];
        b.restart = s_axis_tuser[1];
        b.hi = s_axis_tdata[63:0];
        b.lo = s_axis_tdata[127:64];
        cipher_step(b, res);
        expected_blocks.push_back(res);
        blocks_taken++;
      end
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_block(input logic act, input logic [63:0] hi, input logic [63:0] lo,
                           input logic rs);
    block_req_t b;
    b.action = act;
    b.restart = rs;
    b.hi = hi;
    b.lo = lo;
    pending_blocks.push_back(b);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_KEY_HIGH:   begin key_hi = val; expand_key(); end
      REG_KEY_LOW:    begin key_lo = val; expand_key(); end
      REG_IV_HIGH:    iv_hi = val;
      REG_IV_LOW:     iv_lo = val;
      REG_CHAIN_MODE: cbc_on = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_blocks.size() > 0 || s_axis_tvalid || expected_blocks.size() > 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    int run_len;
    logic act;
    expand_key();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // All-zero key after reset, ECB.
    add_block(1'b0, '0, '0, 1'b0);
    add_block(1'b1, '0, '0, 1'b0);
    add_block(1'b0, '1, '1, 1'b0);
    add_block(1'b1, '1, '1, 1'b0);
    add_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
    add_block(1'b1, 64'h8000000000000001, 64'h0123456789abcdef, 1'b0);
    drain();

    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_IV_HIGH, '1);
    write_reg(REG_IV_LOW, '1);
    write_reg(REG_CHAIN_MODE, {$urandom, $urandom} | 64'd1);
    for (int k = 1; k <= 3; k++) write_reg(CfgIdxW'(REG_CHAIN_MODE + k), {$urandom, $urandom});

    // CBC chains in both directions, with restarts and a direction change mid-chain.
    add_block(1'b0, '0, '0, 1'b1);
    add_block(1'b0, '1, '0, 1'b0);
    add_block(1'b0, 64'hdeadbeefcafef00d, '1, 1'b0);
    add_block(1'b1, '0, '1, 1'b1);
    add_block(1'b1, '1, '1, 1'b0);
    add_block(1'b1, 64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 1'b0);
    add_block(1'b0, 64'h1234, 64'h5678, 1'b0);
    add_block(1'b1, 64'h1234, 64'h5678, 1'b0);
    add_block(1'b0, '0, '0, 1'b1);
    drain();
    write_reg(REG_CHAIN_MODE, '0);
    add_block(1'b0, '1, '0, 1'b1);
    add_block(1'b1, '0, '1, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_KEY_HIGH, rand64());
      write_reg(REG_KEY_LOW, rand64());
      write_reg(REG_IV_HIGH, rand64());
      write_reg(REG_IV_LOW, rand64());
      write_reg(REG_CHAIN_MODE, ({$urandom, $urandom} & ~64'd1) | 64'(ph % 3 != 0));
      if (ph == 7) idle_on = 1'b0;
      if (ph == 2) hold_req++;
      for (int n = 0; n < 235; n += run_len) begin
        run_len = $urandom_range(1, 8);
        act = 1'($urandom_range(0, 1));
        for (int j = 0; j < run_len; j++) begin
          if ($urandom_range(0, 4) == 0)
            add_block(1'($urandom_range(0, 1)), rand64(), rand64(),
                      1'($urandom_range(0, 1)));
          else
            add_block(act, rand64(), rand64(), j == 0);
        end
      end
      drain();
    end

    repeat (30) @(posedge clk);
    $display("Checked %0d result beats over ECB and CBC, both directions, ten key settings.",
             results_seen);
    if (errors == 0) begin
      $display("custom_sbox_aes128_ecb_cbc_tb: done, clean");
    end else begin
      $display("custom_sbox_aes128_ecb_cbc_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("custom_sbox_aes128_ecb_cbc_tb: done, errors");
    $finish;
  end

endmodule
